FILE: rtl/fsmf_pkg.sv
`timescale 1ns / 1ps
// fsmf_pkg: shared constants and types for the first substring match finder
// no dependencies; used by the interfaces, the match cell and the top level

package fsmf_pkg;

	localparam int PAT_MAX_DEF  = 64;
	localparam int TEXT_MAX_DEF = 4096;

	localparam int BYTE_W = 8;
	localparam int IDX_W  = 12;
	// wide enough for any position (TEXT_MAX up to 65536) minus any length
	localparam int DIFF_W = 17;

	typedef enum logic {
		ACT_PATTERN = 1'b0,
		ACT_TEXT    = 1'b1
	} action_t;

	// broadcast controls for every cell of the chain
	typedef struct packed {
		logic              load;
		logic              step;
		logic              clr;
		logic [BYTE_W-1:0] data;
	} cell_ctl_t;

endpackage

FILE: rtl/fsmf_if.sv
`timescale 1ns / 1ps
// fsmf_in_if / fsmf_out_if: valid-ready channels of the match finder
// depends on fsmf_pkg for field widths

interface fsmf_in_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [fsmf_pkg::BYTE_W-1:0] data_byte;
	logic                        last;

	modport source (output valid, output action, output data_byte, output last, input ready);
	modport sink (input valid, input action, input data_byte, input last, output ready);
endinterface

interface fsmf_out_if;
	logic                       valid;
	logic                       ready;
	logic                       found;
	logic [fsmf_pkg::IDX_W-1:0] match_index;
	logic                       overflow;

	modport source (output valid, output found, output match_index, output overflow,
		input ready);
	modport sink (input valid, input found, input match_index, input overflow,
		output ready);
endinterface

FILE: rtl/fsmf_cell.sv
`timescale 1ns / 1ps
// fsmf_cell: one pattern position of the comparator chain
// holds a pattern byte, a tail mark and the partial-match flag; uses fsmf_pkg

module fsmf_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  fsmf_pkg::cell_ctl_t ctl,
	input  logic                sel,
	input  logic                prev_run,
	output logic                run,
	output logic                hit
);
	import fsmf_pkg::*;

	logic [BYTE_W-1:0] pat_q;
	logic              tail_q;
	logic              run_q;
	logic              run_d;

	// pattern prefix ending here matches the newest text bytes
	assign run_d = prev_run && (ctl.data == pat_q);
	assign run   = run_q;
	assign hit   = run_d && tail_q;

	always_ff @(posedge clk) begin
		if (ctl.load && sel) begin
			pat_q <= ctl.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= 1'b0;
			run_q  <= 1'b0;
		end else begin
			if (ctl.load) begin
				tail_q <= sel;
			end
			if (ctl.clr) begin
				run_q <= 1'b0;
			end else if (ctl.step) begin
				run_q <= run_d;
			end
		end
	end

endmodule

FILE: rtl/first_substring_match_finder_top.sv
`timescale 1ns / 1ps
// first_substring_match_finder_top: pattern load, text streaming, result register
// depends on fsmf_pkg, fsmf_in_if / fsmf_out_if and fsmf_cell
//
//  channel   dir   payload                           transaction
//  text_in   in    action, data_byte, last           valid & ready
//  result    out   found, match_index, overflow      valid & ready
//
// one byte per cycle; each byte updates all PAT_MAX cells of the chain at once,
// and the result of a last text byte is registered in the cycle after it.
// reset leaves an empty pattern and a cleared text state.
// text_in stalls only while a result waits in the output register and result
// is not ready; pattern and text bytes are otherwise taken every cycle.

module first_substring_match_finder_top #(
	parameter int PAT_MAX  = fsmf_pkg::PAT_MAX_DEF,
	parameter int TEXT_MAX = fsmf_pkg::TEXT_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	fsmf_in_if.sink           text_in,
	fsmf_out_if.source        result
);
	import fsmf_pkg::*;

	localparam int LEN_W = $clog2(PAT_MAX + 1);
	localparam int POS_W = $clog2(TEXT_MAX + 1);

	logic [LEN_W-1:0]  pat_len_q;
	logic              pat_closed_q;
	logic              pat_trunc_q;
	logic [POS_W-1:0]  pos_q;
	logic              seen_q;
	logic [IDX_W-1:0]  start_q;
	logic              bound_q;

	logic              out_valid_q;
	logic              found_q;
	logic [IDX_W-1:0]  index_q;
	logic              ovf_q;

	logic              acc;
	logic              is_text;
	logic              start_new;
	logic [LEN_W-1:0]  len_eff;
	logic              keep;
	logic              in_range;
	logic              end_text;
	logic              hit_any;
	logic [DIFF_W-1:0] diff;
	logic [IDX_W-1:0]  new_start;
	cell_ctl_t         ctl;

	logic [PAT_MAX:0]   run_vec;
	logic [PAT_MAX-1:0] hit_vec;

	assign text_in.ready = !out_valid_q || result.ready;
	assign acc           = text_in.valid && text_in.ready;
	assign is_text       = (action_t'(text_in.action) == ACT_TEXT);

	assign start_new = pat_closed_q;
	assign len_eff   = start_new ? '0 : pat_len_q;
	assign keep      = (len_eff < LEN_W'(PAT_MAX));
	assign in_range  = (pos_q < POS_W'(TEXT_MAX));
	assign end_text  = acc && is_text && text_in.last;

	assign ctl.load = acc && !is_text && keep;
	assign ctl.step = acc && is_text && in_range;
	assign ctl.clr  = end_text || (acc && !is_text && start_new);
	assign ctl.data = text_in.data_byte;

	assign run_vec[0] = 1'b1;

	for (genvar k = 0; k < PAT_MAX; k++) begin : g_cell
		fsmf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.sel      (len_eff == LEN_W'(k)),
			.prev_run (run_vec[k]),
			.run      (run_vec[k+1]),
			.hit      (hit_vec[k])
		);
	end

	assign hit_any   = ctl.step && (|hit_vec);
	assign diff      = DIFF_W'(pos_q) + DIFF_W'(1) - DIFF_W'(pat_len_q);
	assign new_start = diff[IDX_W-1:0];

	// pattern side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q    <= '0;
			pat_closed_q <= 1'b1;
			pat_trunc_q  <= 1'b0;
		end else if (acc) begin
			if (is_text) begin
				pat_closed_q <= 1'b1;
			end else begin
				pat_len_q    <= keep ? len_eff + LEN_W'(1) : len_eff;
				pat_trunc_q  <= (start_new ? 1'b0 : pat_trunc_q) || !keep;
				pat_closed_q <= text_in.last;
			end
		end
	end

	// text side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			seen_q  <= 1'b0;
			start_q <= '0;
			bound_q <= 1'b0;
		end else if (ctl.clr) begin
			pos_q   <= '0;
			seen_q  <= 1'b0;
			start_q <= '0;
			bound_q <= 1'b0;
		end else if (acc && is_text) begin
			if (in_range) begin
				pos_q <= pos_q + POS_W'(1);
				if (!seen_q && hit_any) begin
					seen_q  <= 1'b1;
					start_q <= new_start;
				end
			end else begin
				bound_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (end_text) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (end_text) begin
			found_q <= seen_q || hit_any;
			if (seen_q) begin
				index_q <= start_q;
			end else if (hit_any) begin
				index_q <= new_start;
			end else begin
				index_q <= '0;
			end
			ovf_q <= bound_q || !in_range || pat_trunc_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.found       = found_q;
	assign result.match_index = index_q;
	assign result.overflow    = ovf_q;

endmodule

FILE: tb/tb_first_substring_match_finder_top.sv
`timescale 1ns / 1ps
// tb_first_substring_match_finder_top: self-checking bench for the substring match finder
// depends on fsmf_pkg, fsmf_in_if / fsmf_out_if and first_substring_match_finder_top;
// directed table first, then random pattern / text sequences checked against a predictor

module tb_first_substring_match_finder_top;
	import fsmf_pkg::*;

	localparam int PAT_MAX  = PAT_MAX_DEF;
	localparam int TEXT_MAX = TEXT_MAX_DEF;
	localparam int RANDOM_ITEMS = 1450;

	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  idx;
		logic              ovf;
	} match_t;

	typedef struct packed {
		action_t           act;
		logic [BYTE_W-1:0] b;
		logic              lst;
		logic              typed;
		match_t            res;
	} step_row_t;

	// rows with typed set carry a result that is known without the predictor
	localparam int N_DIRECTED = 23;
	localparam step_row_t DIRECTED [N_DIRECTED] = '{
		'{ACT_TEXT,    8'h61, 1'b1, 1'b1, '{1'b0, 12'd0, 1'b0}},
		'{ACT_PATTERN, 8'h61, 1'b0, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{ACT_PATTERN, 8'h62, 1'b1, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{ACT_TEXT,    8'h78, 1'b0, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{ACT_TEXT,    8'h61, 1'b0, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{ACT_TEXT,    8'h62, 1'b1, 1'b1, '{1'b1, 12'd1, 1'b0}},
		'{ACT_PATTERN, 8'hFF, 1'b1, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{ACT_TEXT,    8'h00, 1'b0, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{ACT_TEXT,    8'hFF, 1'b1, 1'b1, '{1'b1, 12'd1, 1'b0}},
		'{ACT_TEXT,    8'h00, 1'b0, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{ACT_PATTERN, 8'h00, 1'b0, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{ACT_TEXT,    8'h00, 1'b1, 1'b1, '{1'b1, 12'd0, 1'b0}},
		'{ACT_PATTERN, 8'h55, 1'b1, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{ACT_TEXT,    8'hAA, 1'b0, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{ACT_TEXT,    8'h7F, 1'b1, 1'b1, '{1'b0, 12'd0, 1'b0}},
		'{ACT_TEXT,    8'h55, 1'b1, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{ACT_PATTERN, 8'h01, 1'b0, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{ACT_PATTERN, 8'h02, 1'b0, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{ACT_PATTERN, 8'h01, 1'b1, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{ACT_TEXT,    8'h01, 1'b0, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{ACT_TEXT,    8'h02, 1'b0, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{ACT_TEXT,    8'h01, 1'b1, 1'b0, '{1'b0, 12'd0, 1'b0}},
		'{ACT_TEXT,    8'h01, 1'b1, 1'b0, '{1'b0, 12'd0, 1'b0}}
	};

	bit   clk = 1'b0;
	logic arst_n = 1'b0;

	bit                src_valid = 1'b0;
	action_t           src_act = ACT_PATTERN;
	bit [BYTE_W-1:0]   src_byte = '0;
	bit                src_last = 1'b0;
	bit                snk_ready = 1'b0;
	bit                calm = 1'b0;
	int                mismatches = 0;

	fsmf_in_if  text_in();
	fsmf_out_if result();

	assign text_in.valid     = src_valid;
	assign text_in.action    = src_act;
	assign text_in.data_byte = src_byte;
	assign text_in.last      = src_last;
	assign result.ready      = snk_ready;

	first_substring_match_finder_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_in (text_in),
		.result  (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// search state mirrored by the predictor
	logic [BYTE_W-1:0] pat_mem [PAT_MAX];
	int unsigned       pat_len = 0;
	bit                pat_closed = 1'b1;
	bit                pat_trunc = 1'b0;
	logic [BYTE_W-1:0] win [PAT_MAX] = '{default: 8'h00};
	int unsigned       txt_pos = 0;
	bit                hit = 1'b0;
	int unsigned       hit_at = 0;
	bit                past_end = 1'b0;

	match_t pending_matches [$];
	match_t want;

	function automatic void clear_text();
		foreach (win[k])
			win[k] = 8'h00;
		txt_pos  = 0;
		hit      = 1'b0;
		hit_at   = 0;
		past_end = 1'b0;
	endfunction

	function automatic bit advance_search(input action_t act, input logic [BYTE_W-1:0] b,
		input bit lst, output match_t res);
		bit same;
		res = '0;
		if (act == ACT_PATTERN) begin
			if (pat_closed) begin
				pat_len    = 0;
				pat_trunc  = 1'b0;
				pat_closed = 1'b0;
				clear_text();
			end
			if (pat_len < PAT_MAX) begin
				pat_mem[pat_len] = b;
				pat_len++;
			end else begin
				pat_trunc = 1'b1;
			end
			if (lst)
				pat_closed = 1'b1;
			return 1'b0;
		end
		// a text byte closes the pattern even without its last flag
		pat_closed = 1'b1;
		if (txt_pos < TEXT_MAX) begin
			for (int k = 0; k < PAT_MAX - 1; k++)
				win[k] = win[k+1];
			win[PAT_MAX-1] = b;
			if (!hit && pat_len > 0 && txt_pos + 1 >= pat_len) begin
				same = 1'b1;
				for (int k = 0; k < pat_len; k++)
					if (win[PAT_MAX - pat_len + k] !== pat_mem[k])
						same = 1'b0;
				if (same) begin
					hit    = 1'b1;
					hit_at = txt_pos + 1 - pat_len;
				end
			end
			txt_pos++;
		end else begin
			past_end = 1'b1;
		end
		if (!lst)
			return 1'b0;
		res.found = hit;
		res.idx   = hit ? hit_at[IDX_W-1:0] : '0;
		res.ovf   = past_end || pat_trunc;
		clear_text();
		return 1'b1;
	endfunction

	task automatic send_byte(input action_t act, input logic [BYTE_W-1:0] b, input bit lst,
		input bit typed, input match_t typed_res);
		match_t res;
		while (!calm && $urandom_range(99) < 24) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_act   <= act;
		src_byte  <= b;
		src_last  <= lst;
		do
			@(posedge clk);
		while (!text_in.ready);
		if (advance_search(act, b, lst, res))
			pending_matches.push_back(typed ? typed_res : res);
	endtask

	function automatic logic [BYTE_W-1:0] draw_char(input bit full, input logic [BYTE_W-1:0] a0,
		input logic [BYTE_W-1:0] a1);
		if (full)
			return BYTE_W'($urandom_range(255));
		return $urandom_range(1) ? a0 : a1;
	endfunction

	always @(posedge clk) begin
		if (arst_n)
			snk_ready <= calm || ($urandom_range(99) >= 24);
	end

	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			if (pending_matches.size() == 0) begin
				$error("result transaction with no expectation pending");
				mismatches++;
			end else begin
				want = pending_matches.pop_front();
				if (result.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, result.found);
					mismatches++;
				end
				if (result.match_index !== want.idx) begin
					$error("match_index: expected %0d, got %0d", want.idx, result.match_index);
					mismatches++;
				end
				if (result.overflow !== want.ovf) begin
					$error("overflow: expected %0d, got %0d", want.ovf, result.overflow);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [BYTE_W-1:0] pat_buf [80];
		logic [BYTE_W-1:0] txt_buf [128];
		logic [BYTE_W-1:0] a0;
		logic [BYTE_W-1:0] a1;
		int  rnd_items;
		int  r;
		int  plen;
		int  tlen;
		int  at;
		int  cut;
		bit  full;
		bit  close_pat;
		bit  abort_txt;
		bit  have_pat;

		rnd_items = 0;
		plen      = 0;
		have_pat  = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i].act, DIRECTED[i].b, DIRECTED[i].lst, DIRECTED[i].typed,
				DIRECTED[i].res);

		while (rnd_items < RANDOM_ITEMS) begin
			calm = (rnd_items >= 400 && rnd_items < 600);

			r    = $urandom_range(99);
			full = $urandom_range(99) < 20;
			a0   = BYTE_W'($urandom);
			a1   = BYTE_W'($urandom);

			if (!have_pat || r >= 10) begin
				plen = (r < 16) ? $urandom_range(PAT_MAX - 4, PAT_MAX + 6) : $urandom_range(1, 6);
				close_pat = $urandom_range(99) < 85;
				for (int i = 0; i < plen; i++) begin
					pat_buf[i] = draw_char(full, a0, a1);
					send_byte(ACT_PATTERN, pat_buf[i], close_pat && i == plen - 1, 1'b0, '0);
					rnd_items++;
				end
				have_pat = 1'b1;
			end

			tlen = (plen > 8) ? $urandom_range(plen - 4, plen + 20) : $urandom_range(1, 30);
			for (int i = 0; i < tlen; i++)
				txt_buf[i] = draw_char(full, a0, a1);
			if (plen <= tlen && $urandom_range(99) < 60) begin
				at = $urandom_range(0, tlen - plen);
				for (int i = 0; i < plen; i++)
					txt_buf[at + i] = pat_buf[i];
			end

			// an aborted text leaves its state to the next pattern or text
			abort_txt = $urandom_range(99) < 8;
			cut = abort_txt ? $urandom_range(1, tlen) : tlen;
			for (int i = 0; i < cut; i++) begin
				send_byte(ACT_TEXT, txt_buf[i], !abort_txt && i == tlen - 1, 1'b0, '0);
				rnd_items++;
			end
		end
		src_valid <= 1'b0;

		for (int w = 0; w < 5000 && pending_matches.size() != 0; w++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (pending_matches.size() != 0) begin
			$error("%0d expected results never arrived", pending_matches.size());
			mismatches++;
		end

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
